// ===== hw/rtl/gift64_pkg.sv =====
`timescale 1ns / 1ps

package gift64_pkg;

  // Configuration register indexes.
  localparam logic REG_KEY_UPPER = 1'b0;
  localparam logic REG_KEY_LOWER = 1'b1;

  typedef logic [63:0]  block_t;
  typedef logic [127:0] key_state_t;
  typedef logic [5:0]   round_const_t;

  // GIFT 4-bit S-box.
  localparam logic [3:0] SBOX [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };

  function automatic block_t sub_nibbles(input block_t x);
    block_t y;
    y = '0;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Fixed GIFT-64 bit permutation; every index is settled at elaboration.
  function automatic block_t permute_bits(input block_t x);
    block_t y;
    int     q;
    int     m;
    int     b;
    int     d;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      q = i / 16;
      m = i % 16;
      b = i % 4;
      d = 4 * q + 16 * ((3 * (m / 4) + b) % 4) + b;
      y[d[5:0]] = x[i];
    end
    return y;
  endfunction

  // Round-key bit s lands on bit 4s, round-key bit 16+s on bit 4s+1.
  function automatic block_t add_round_key(input block_t x, input logic [31:0] rk);
    block_t y;
    y = x;
    for (int s = 0; s < 16; s++) begin
      y[4*s]     = x[4*s]     ^ rk[s];
      y[4*s + 1] = x[4*s + 1] ^ rk[16 + s];
    end
    return y;
  endfunction

  // Key state update: k7..k0 <- (k1 >>> 2) | (k0 >>> 12) | k7 | k6 | k5 | k4 | k3 | k2.
  function automatic key_state_t key_update(input key_state_t k);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = k[127:64];
    lo = k[63:0];
    return {lo[17:16], lo[31:18], lo[11:0], lo[15:12], hi[63:32],
            hi[31:0], lo[63:32]};
  endfunction

  function automatic round_const_t rc_step(input round_const_t c);
    return {c[4:0], c[5] ^ c[4] ^ 1'b1};
  endfunction

endpackage

// ===== hw/rtl/gift64_round_cell.sv =====
`timescale 1ns / 1ps

module gift64_round_cell
  import gift64_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  block_t       in_data,
  input  logic [31:0]  round_key,
  input  round_const_t round_const,
  output logic         out_valid,
  input  logic         out_ready,
  output block_t       out_data
);

  logic   valid;
  block_t data;
  block_t data_next;

  always_comb begin
    data_next = permute_bits(sub_nibbles(in_data));
    data_next[63] = ~data_next[63];
    data_next[23] = data_next[23] ^ round_const[5];
    data_next[19] = data_next[19] ^ round_const[4];
    data_next[15] = data_next[15] ^ round_const[3];
    data_next[11] = data_next[11] ^ round_const[2];
    data_next[7]  = data_next[7]  ^ round_const[1];
    data_next[3]  = data_next[3]  ^ round_const[0];
    data_next = add_round_key(data_next, round_key);
  end

  // The cell takes a new block when it is empty or its block moves on.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== hw/rtl/gift64_reduced_round_encrypt.sv =====
`timescale 1ns / 1ps

// Reduced-round GIFT-64 encryption, one round per cell in a chain of cells.
// Input channel: plaintext beats under in_valid / in_ready. Output channel:
// ciphertext beats under out_valid / out_ready. Each beat is encrypted on
// its own with the 128-bit key in key_upper (words k7..k4) and key_lower
// (words k3..k0), written through cfg_we / cfg_index / cfg_data while no
// beat is in flight.
// Each beat passes through the chain one cell per round. Every cell
// holds one block and hands it to the next cell each cycle, so a new beat
// is taken in every cycle while the output side keeps up.
// When the receiver stalls, the last cell holds its block; the cells before
// it keep filling until each is occupied, so up to ROUND_COUNT beats are
// buffered before in_ready falls.
// Reset (synchronous, active high) empties every cell and clears both key
// registers to zero.
// Round keys and round constants depend only on the key registers and the
// round number, so they are formed by fixed wiring beside the chain.

module gift64_reduced_round_encrypt
  import gift64_pkg::*;
#(
  parameter int ROUND_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] plaintext,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] ciphertext,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_upper;
  logic [63:0] key_lower;

  // The user must write the key registers only while the chain is empty; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_UPPER: key_upper <= cfg_data;
        REG_KEY_LOWER: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and data links between neighbouring cells; link 0 is the
  // input port and link ROUND_COUNT the output port.
  logic         link_valid [ROUND_COUNT+1];
  logic         link_ready [ROUND_COUNT+1];
  block_t       link_data  [ROUND_COUNT+1];
  key_state_t   key_chain  [ROUND_COUNT];
  round_const_t rc_chain   [ROUND_COUNT+1];

  assign link_valid[0] = in_valid;
  assign in_ready      = link_ready[0];
  assign link_data[0]  = plaintext;

  assign out_valid               = link_valid[ROUND_COUNT];
  assign link_ready[ROUND_COUNT] = out_ready;
  assign ciphertext              = link_data[ROUND_COUNT];

  // The constant LFSR starts at zero and steps before each round.
  assign key_chain[0] = {key_upper, key_lower};
  assign rc_chain[0]  = '0;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    assign rc_chain[r+1] = rc_step(rc_chain[r]);

    if (r + 1 < ROUND_COUNT) begin : g_key
      assign key_chain[r+1] = key_update(key_chain[r]);
    end

    gift64_round_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (link_valid[r]),
      .in_ready    (link_ready[r]),
      .in_data     (link_data[r]),
      .round_key   (key_chain[r][31:0]),
      .round_const (rc_chain[r+1]),
      .out_valid   (link_valid[r+1]),
      .out_ready   (link_ready[r+1]),
      .out_data    (link_data[r+1])
    );
  end

endmodule
